// ===== rtl/core/block_linear_gob_deswizzle_core_assert.svh =====
// Assertion macros shared by the de-swizzle core.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef BLOCK_LINEAR_GOB_DESWIZZLE_CORE_ASSERT_SVH
`define BLOCK_LINEAR_GOB_DESWIZZLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BGD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bgd assertion failed");

// Next-cycle implication, disabled during reset.
`define BGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bgd assertion failed");

`endif

// ===== rtl/core/bgd_pkg.sv =====
// Shared types and constants of the block-linear GOB de-swizzle core.
// Used by the channel interfaces and every module of the core.
package bgd_pkg;

  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 30;
  localparam int STRIDE_W   = 17;
  localparam int HEIGHT_W   = 15;
  localparam int BHL_W      = 3;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  // GOB geometry: 64 bytes wide, 8 rows high, 32 chunks of 16 bytes.
  localparam int GOB_WIDTH  = 64;
  localparam int GOB_ROWS   = 8;
  localparam int GOB_CHUNKS = 32;
  localparam int CHUNK_W    = 5;
  localparam int GOB_ROW_W  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_STRIDE   = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_GOBS_LOG2    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic write_enable;
    logic last_chunk;
  } chunk_flags_t;

  typedef struct packed {
    logic at_origin;    // all position counters are zero
    logic pushed_last;  // the chunk transferred this cycle ends the image
  } front_status_t;

endpackage

// ===== rtl/core/bgd_stream_if.sv =====
// Channel interfaces of the de-swizzle core: input chunks and results.
// Depends on bgd_pkg for the field widths.
interface bgd_chunk_if
  import bgd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_low;
  logic [DATA_W-1:0] data_high;

  modport source (output valid, data_low, data_high, input ready);
  modport sink (input valid, data_low, data_high, output ready);
endinterface

interface bgd_result_if
  import bgd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] dest_address;
  logic [DATA_W-1:0] out_low;
  logic [DATA_W-1:0] out_high;
  logic              write_enable;
  logic              last_chunk;

  modport source (output valid, dest_address, out_low, out_high, write_enable, last_chunk,
                  input ready);
  modport sink (input valid, dest_address, out_low, out_high, write_enable, last_chunk,
                output ready);
endinterface

// ===== rtl/core/block_linear_gob_deswizzle_core.sv =====
// Block-linear GOB de-swizzle core. It takes a block-linear texture as a
// stream of 16-byte chunks and returns, for every chunk, the chunk's data
// together with its byte address in the linear image (modulo 2^30), a write
// enable that is low for chunks of GOBs starting at or below the image
// height (their address reads as zero), and a last flag on the final chunk
// of the image, after which the position wraps to the origin. One chunk is
// taken per clock cycle, sustained; the front position counters advance in
// a single step per transfer, and the address multiply is pipelined, so no
// loop limits the rate. A result reaches the result channel through the
// queue register, the multiply register and the output register, in that
// order. Back-pressure on the result channel fills a
// four-entry queue before the chunk channel drops ready. Registers are
// written through cfg_write/cfg_index/cfg_data: row_stride at index 0,
// image_height at index 1, the log2 of GOBs per block at index 2; they must
// only be changed while the core holds no chunk whose result is still
// undelivered.
// Depends on bgd_pkg, the channel interfaces, bgd_front, bgd_queue, bgd_back.
module block_linear_gob_deswizzle_core
  import bgd_pkg::*;
#(
  parameter int MAX_STRIDE    = 65536,
  parameter int MAX_HEIGHT    = 16384,
  parameter int MAX_GOBS_LOG2 = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bgd_chunk_if.sink             chunk,
  bgd_result_if.source          result
);

  // The widest stride and height the registers can reach set the width of
  // the block column and block row counters.
  localparam int STRIDE_LIM  = (MAX_STRIDE < 131071) ? MAX_STRIDE : 131071;
  localparam int WB_MAX      = (STRIDE_LIM / GOB_WIDTH > 0) ? STRIDE_LIM / GOB_WIDTH : 1;
  localparam int COL_W       = (WB_MAX > 1) ? $clog2(WB_MAX) : 1;
  localparam int HEIGHT_LIM  = (MAX_HEIGHT < 32767) ? MAX_HEIGHT : 32767;
  localparam int HB_MAX      = (HEIGHT_LIM + GOB_ROWS - 1) / GOB_ROWS;
  localparam int ROW_W       = (HB_MAX > 1) ? $clog2(HB_MAX) : 1;
  localparam int GY_W        = ROW_W + 9;
  localparam int OFF_W       = COL_W + 6;
  localparam int ENTRY_W     = 2 * DATA_W + GY_W + OFF_W + $bits(chunk_flags_t);
  localparam int QUEUE_DEPTH = 4;

  logic [STRIDE_W-1:0] row_stride;
  logic [HEIGHT_W-1:0] image_height;
  logic [BHL_W-1:0]    gobs_log2;

  logic                push;
  logic                pop;
  logic [ENTRY_W-1:0]  push_entry;
  logic [ENTRY_W-1:0]  pop_entry;
  logic                queue_empty;
  logic                queue_full;
  logic [STRIDE_W-1:0] eff_stride;
  front_status_t       front_status;

  // Configuration registers. Writes to an index outside the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride   <= STRIDE_W'(64);
      image_height <= HEIGHT_W'(1);
      gobs_log2    <= BHL_W'(4);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW_STRIDE:   row_stride   <= cfg_data[STRIDE_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        CFG_GOBS_LOG2:    gobs_log2    <= cfg_data[BHL_W-1:0];
        default: ;
      endcase
    end
  end

  // The front end classifies each chunk and steps the position counters.
  bgd_front #(
    .MAX_STRIDE    (MAX_STRIDE),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .MAX_GOBS_LOG2 (MAX_GOBS_LOG2),
    .ROW_W         (ROW_W),
    .COL_W         (COL_W),
    .GY_W          (GY_W),
    .OFF_W         (OFF_W),
    .ENTRY_W       (ENTRY_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .row_stride   (row_stride),
    .image_height (image_height),
    .gobs_log2    (gobs_log2),
    .chunk        (chunk),
    .queue_full   (queue_full),
    .push         (push),
    .entry        (push_entry),
    .eff_stride   (eff_stride),
    .status       (front_status)
  );

  // The queue lets the front keep taking transfers while results stall.
  bgd_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .pop_data  (pop_entry),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  // The back end computes row * stride + column offset and drives results.
  bgd_back #(
    .ROW_W   (ROW_W),
    .COL_W   (COL_W),
    .GY_W    (GY_W),
    .OFF_W   (OFF_W),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (pop_entry),
    .queue_empty (queue_empty),
    .pop         (pop),
    .eff_stride  (eff_stride),
    .result      (result)
  );

`include "block_linear_gob_deswizzle_core_assert.svh"

  // A skipped chunk always carries a zero address.
  `BGD_ASSERT_IMPLIES(a_skip_zero_addr, clk, rst, result.valid && !result.write_enable, result.dest_address == '0)

  // The transfer of the final chunk of an image returns the position to the origin.
  `BGD_ASSERT_NEXT(a_last_wraps, clk, rst, front_status.pushed_last, front_status.at_origin)

endmodule

// ===== rtl/core/bgd_front.sv =====
// Front end: takes chunk transfers, tracks the GOB/block position and
// classifies each chunk. Depends on bgd_pkg and bgd_chunk_if.
module bgd_front
  import bgd_pkg::*;
#(
  parameter int MAX_STRIDE    = 65536,
  parameter int MAX_HEIGHT    = 16384,
  parameter int MAX_GOBS_LOG2 = 5,
  parameter int ROW_W         = 11,
  parameter int COL_W         = 10,
  parameter int GY_W          = ROW_W + 9,
  parameter int OFF_W         = COL_W + 6,
  parameter int ENTRY_W       = 2 * DATA_W + GY_W + OFF_W + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [STRIDE_W-1:0]  row_stride,
  input  logic [HEIGHT_W-1:0]  image_height,
  input  logic [BHL_W-1:0]     gobs_log2,
  bgd_chunk_if.sink            chunk,
  input  logic                 queue_full,
  output logic                 push,
  output logic [ENTRY_W-1:0]   entry,
  output logic [STRIDE_W-1:0]  eff_stride,
  output front_status_t        status
);

  localparam logic [31:0] STRIDE_CAP = 32'(MAX_STRIDE) & ~32'h3F;

  logic [CHUNK_W-1:0]   chunk_index;
  logic [GOB_ROW_W-1:0] gob_row;
  logic [COL_W-1:0]     block_column;
  logic [ROW_W-1:0]     block_row;

  logic [STRIDE_W-1:0]  stride_masked;
  logic [HEIGHT_W-1:0]  height;
  logic [BHL_W-1:0]     bhl;
  logic [8:0]           block_px;
  logic [15:0]          block_row_count;
  logic [10:0]          block_col_count;
  logic [2:0]           local_y;
  logic [1:0]           local_x;
  logic [GY_W-1:0]      gob_y;
  logic [GY_W-1:0]      row_index;
  logic [OFF_W-1:0]     offset;
  chunk_flags_t         flags;
  logic                 end_chunk;
  logic                 end_gob;
  logic                 end_col;
  logic                 end_row;
  logic                 accept;

  // Effective register values after clamping.
  always_comb begin
    stride_masked = {row_stride[STRIDE_W-1:6], 6'b0};
    eff_stride    = stride_masked;
    if (32'(stride_masked) > STRIDE_CAP) begin
      eff_stride = STRIDE_CAP[STRIDE_W-1:0];
    end
    if (32'(eff_stride) < 32'(GOB_WIDTH)) begin
      eff_stride = STRIDE_W'(GOB_WIDTH);
    end
    height = image_height;
    if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      height = HEIGHT_W'(MAX_HEIGHT);
    end
    if (height == '0) begin
      height = HEIGHT_W'(1);
    end
    bhl = gobs_log2;
    if (gobs_log2 > BHL_W'(MAX_GOBS_LOG2)) begin
      bhl = BHL_W'(MAX_GOBS_LOG2);
    end
  end

  assign block_px        = 9'(GOB_ROWS) << bhl;
  assign block_row_count = (16'(height) + 16'(block_px) - 16'd1) >> (4'd3 + 4'(bhl));
  assign block_col_count = eff_stride[STRIDE_W-1:6];

  // Position of the chunk inside its GOB.
  assign local_y = {chunk_index[3:2], chunk_index[0]};
  assign local_x = {chunk_index[4], chunk_index[1]};

  assign gob_y     = (GY_W'(block_row) << (4'd3 + 4'(bhl))) + GY_W'({gob_row, 3'b000});
  assign row_index = gob_y + GY_W'(local_y);
  assign offset    = {block_column, local_x, 4'b0000};

  assign end_chunk = chunk_index >= CHUNK_W'(GOB_CHUNKS - 1);
  assign end_gob   = 32'(gob_row) >= (32'(1) << bhl) - 32'd1;
  assign end_col   = 32'(block_column) >= 32'(block_col_count) - 32'd1;
  assign end_row   = 32'(block_row) >= 32'(block_row_count) - 32'd1;

  assign flags.write_enable = 32'(gob_y) < 32'(height);
  assign flags.last_chunk   = end_chunk && end_gob && end_col && end_row;

  assign chunk.ready = !queue_full;
  assign accept      = chunk.valid && chunk.ready;
  assign push        = accept;
  assign entry       = {chunk.data_high, chunk.data_low, row_index, offset, flags};

  assign status.at_origin   = (chunk_index == '0) && (gob_row == '0) &&
                              (block_column == '0) && (block_row == '0);
  assign status.pushed_last = accept && flags.last_chunk;

  // Nested position counters; each wraps and carries at its end.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_index  <= '0;
      gob_row      <= '0;
      block_column <= '0;
      block_row    <= '0;
    end else if (accept) begin
      if (!end_chunk) begin
        chunk_index <= chunk_index + CHUNK_W'(1);
      end else begin
        chunk_index <= '0;
        if (!end_gob) begin
          gob_row <= gob_row + GOB_ROW_W'(1);
        end else begin
          gob_row <= '0;
          if (!end_col) begin
            block_column <= block_column + COL_W'(1);
          end else begin
            block_column <= '0;
            if (!end_row) begin
              block_row <= block_row + ROW_W'(1);
            end else begin
              block_row <= '0;
            end
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/bgd_queue.sv =====
// Short register queue between the front end and the address back end.
// Depends on bgd_pkg only for the common import.
module bgd_queue
  import bgd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign empty    = count == '0;
  assign full     = count == COUNT_W'(DEPTH);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/bgd_back.sv =====
// Back end: forms the linear byte address of each queued chunk in a
// multiply stage and an add stage. Depends on bgd_pkg and bgd_result_if.
module bgd_back
  import bgd_pkg::*;
#(
  parameter int ROW_W   = 11,
  parameter int COL_W   = 10,
  parameter int GY_W    = ROW_W + 9,
  parameter int OFF_W   = COL_W + 6,
  parameter int ENTRY_W = 2 * DATA_W + GY_W + OFF_W + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ENTRY_W-1:0]  entry,
  input  logic                queue_empty,
  output logic                pop,
  input  logic [STRIDE_W-1:0] eff_stride,
  bgd_result_if.source        result
);

  logic [DATA_W-1:0] q_high;
  logic [DATA_W-1:0] q_low;
  logic [GY_W-1:0]   q_row;
  logic [OFF_W-1:0]  q_offset;
  chunk_flags_t      q_flags;

  // Multiply stage.
  logic              mul_valid;
  logic [ADDR_W-1:0] mul_product;
  logic [OFF_W-1:0]  mul_offset;
  chunk_flags_t      mul_flags;
  logic [DATA_W-1:0] mul_low;
  logic [DATA_W-1:0] mul_high;

  logic              advance_out;
  logic              mul_free;

  assign {q_high, q_low, q_row, q_offset, q_flags} = entry;

  assign advance_out = !result.valid || result.ready;
  assign mul_free    = !mul_valid || advance_out;
  assign pop         = mul_free && !queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid    <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (mul_free) begin
        mul_valid <= !queue_empty;
      end
      if (advance_out) begin
        result.valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mul_product <= ADDR_W'(q_row) * ADDR_W'(eff_stride);
      mul_offset  <= q_offset;
      mul_flags   <= q_flags;
      mul_low     <= q_low;
      mul_high    <= q_high;
    end
    if (advance_out && mul_valid) begin
      result.dest_address <= mul_flags.write_enable ?
                             mul_product + ADDR_W'(mul_offset) : '0;
      result.write_enable <= mul_flags.write_enable;
      result.last_chunk   <= mul_flags.last_chunk;
      result.out_low      <= mul_low;
      result.out_high     <= mul_high;
    end
  end

endmodule

// ===== verif/bgd_deswizzle_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the block-linear GOB de-swizzle core: predicts each chunk's placement.
// Depends on bgd_pkg and the chunk and result channel interfaces.
module bgd_deswizzle_checker
  import bgd_pkg::*;
#(
  parameter int MAX_STRIDE    = 65536,
  parameter int MAX_HEIGHT    = 16384,
  parameter int MAX_GOBS_LOG2 = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bgd_chunk_if                  chunk,
  bgd_result_if                 result,
  output int                    mismatches,
  output int                    pending,
  output int                    results_seen,
  output int                    skips_seen,
  output int                    image_ends
);

  typedef struct packed {
    logic [ADDR_W-1:0] dest_address;
    logic [DATA_W-1:0] out_low;
    logic [DATA_W-1:0] out_high;
    logic              write_enable;
    logic              last_chunk;
  } placement_t;

  logic [STRIDE_W-1:0]  stride_reg;
  logic [HEIGHT_W-1:0]  height_reg;
  logic [BHL_W-1:0]     bhl_reg;
  logic [CHUNK_W-1:0]   chunk_pos;
  logic [GOB_ROW_W-1:0] gob_pos;
  logic [9:0]           column_pos;
  logic [10:0]          block_row_pos;

  placement_t expected_placements[$];

  // Works out where one chunk lands and steps the position counters.
  function automatic placement_t place_chunk(input logic [DATA_W-1:0] lo,
                                             input logic [DATA_W-1:0] hi);
    int unsigned     stride;
    int unsigned     height;
    int unsigned     bhl;
    int unsigned     gobs;
    int unsigned     block_px;
    int unsigned     block_col_count;
    int unsigned     block_row_count;
    longint unsigned local_y;
    longint unsigned local_x;
    longint unsigned gob_y;
    longint unsigned addr;
    logic            end_chunk;
    logic            end_gob;
    logic            end_col;
    logic            end_row;
    placement_t      p;

    stride = int'(stride_reg) & 32'hFFFF_FFC0;
    if (stride > MAX_STRIDE) stride = MAX_STRIDE & 32'hFFFF_FFC0;
    if (stride < GOB_WIDTH) stride = GOB_WIDTH;
    height = height_reg;
    if (height > MAX_HEIGHT) height = MAX_HEIGHT;
    if (height == 0) height = 1;
    bhl = bhl_reg;
    if (bhl > MAX_GOBS_LOG2) bhl = MAX_GOBS_LOG2;

    gobs            = 1 << bhl;
    block_px        = GOB_ROWS << bhl;
    block_col_count = stride >> 6;
    block_row_count = (height + block_px - 1) >> (3 + bhl);

    // Sector order inside a GOB: bits 0, 2 and 3 pick the row, bits 1 and 4 the column.
    local_y = {chunk_pos[3:2], chunk_pos[0]};
    local_x = {chunk_pos[4], chunk_pos[1], 4'b0000};
    gob_y   = longint'(block_row_pos) * block_px + longint'(gob_pos) * GOB_ROWS;

    p.write_enable = (gob_y < height);
    addr = 0;
    if (p.write_enable)
      addr = (gob_y + local_y) * stride + longint'(column_pos) * GOB_WIDTH + local_x;
    p.dest_address = addr[ADDR_W-1:0];
    p.out_low      = lo;
    p.out_high     = hi;

    // A counter left beyond its end by a register change counts as being at its end.
    end_chunk    = (chunk_pos >= GOB_CHUNKS - 1);
    end_gob      = (gob_pos >= gobs - 1);
    end_col      = (column_pos >= block_col_count - 1);
    end_row      = (block_row_pos >= block_row_count - 1);
    p.last_chunk = end_chunk && end_gob && end_col && end_row;

    if (!end_chunk) begin
      chunk_pos = chunk_pos + 1'b1;
    end else begin
      chunk_pos = '0;
      if (!end_gob) begin
        gob_pos = gob_pos + 1'b1;
      end else begin
        gob_pos = '0;
        if (!end_col) begin
          column_pos = column_pos + 1'b1;
        end else begin
          column_pos    = '0;
          block_row_pos = end_row ? '0 : block_row_pos + 1'b1;
        end
      end
    end
    return p;
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      stride_reg    = 64;
      height_reg    = 1;
      bhl_reg       = 4;
      chunk_pos     = '0;
      gob_pos       = '0;
      column_pos    = '0;
      block_row_pos = '0;
      expected_placements.delete();
      mismatches    = 0;
      results_seen  = 0;
      skips_seen    = 0;
      image_ends    = 0;
    end else begin
      // Results are matched before this edge's chunk is queued: a result never
      // belongs to a chunk taken at the same edge.
      if (result.valid && result.ready) begin
        results_seen++;
        if (expected_placements.size() == 0) begin
          $error("result transfer with no chunk waiting for it");
          mismatches++;
        end else begin
          want = expected_placements.pop_front();
          check_field("dest_address", want.dest_address, result.dest_address);
          check_field("out_low", want.out_low, result.out_low);
          check_field("out_high", want.out_high, result.out_high);
          check_field("write_enable", want.write_enable, result.write_enable);
          check_field("last_chunk", want.last_chunk, result.last_chunk);
          if (!result.write_enable) skips_seen++;
          if (result.last_chunk) image_ends++;
        end
      end
      if (chunk.valid && chunk.ready)
        expected_placements.push_back(place_chunk(chunk.data_low, chunk.data_high));
      if (cfg_write) begin
        case (cfg_index)
          CFG_ROW_STRIDE:   stride_reg = cfg_data[STRIDE_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
          CFG_GOBS_LOG2:    bhl_reg    = cfg_data[BHL_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_placements.size();
  end

endmodule

// ===== verif/tb_block_linear_gob_deswizzle_core.sv =====
`timescale 1ns / 100ps
// Top of the de-swizzle core testbench: clock, reset, stimulus and the verdict.
// Depends on bgd_pkg, the channel interfaces, the core and bgd_deswizzle_checker.
module tb_block_linear_gob_deswizzle_core;
  import bgd_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int STALL_LIMIT   = 2000;   // cycles with no transfer on either channel
  localparam int PHASES        = 12;
  localparam int PHASE_CHUNKS  = 112;
  localparam int LONG_HOLD     = 300;    // receiver hold-off that fills the core
  localparam int SETTLE_CYCLES = 8;      // idle wait before the verdict

  // Traffic shapes for a phase; the value picks the idle and stall rates.
  typedef enum int {
    TRAFFIC_STEADY,
    TRAFFIC_SENDER_GAPS,
    TRAFFIC_RECEIVER_STALLS,
    TRAFFIC_BOTH
  } traffic_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int sender_idle_pct = 0;
  int rx_stall_pct    = 0;
  int hold_request    = 0;
  int hold_left       = 0;
  int idle_cycles     = 0;
  int chunks_sent     = 0;
  int settings_used   = 0;

  int mismatches;
  int pending;
  int results_seen;
  int skips_seen;
  int image_ends;

  bgd_chunk_if  chunk_ch ();
  bgd_result_if result_ch ();

  block_linear_gob_deswizzle_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chunk     (chunk_ch),
    .result    (result_ch)
  );

  // The checker watches both channels and the register port on its own and
  // reports back how many mismatches it saw and how many results are owed.
  bgd_deswizzle_checker placement_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .chunk        (chunk_ch),
    .result       (result_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .skips_seen   (skips_seen),
    .image_ends   (image_ends)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // The receiver side runs in its own process. A hold-off request parks ready
  // low for a counted stretch; otherwise ready follows the phase's stall rate.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: a run that stops moving is a failure. Transfers are sampled at
  // the rising edge, before the core's registers update.
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (chunk_ch.valid && chunk_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic logic [DATA_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic set_traffic(input traffic_t mode);
    case (mode)
      TRAFFIC_STEADY:          begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
      TRAFFIC_SENDER_GAPS:     begin sender_idle_pct = 64; rx_stall_pct = 0;  end
      TRAFFIC_RECEIVER_STALLS: begin sender_idle_pct = 0;  rx_stall_pct = 64; end
      default:                 begin sender_idle_pct = 36; rx_stall_pct = 36; end
    endcase
  endtask

  // Register writes go out back to back, one per cycle, starting at a falling edge.
  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  task automatic apply_setting(input int unsigned stride, input int unsigned height,
                               input int unsigned bhl);
    write_reg(CFG_ROW_STRIDE, stride);
    write_reg(CFG_IMAGE_HEIGHT, height);
    write_reg(CFG_GOBS_LOG2, bhl);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Stops offering chunks and waits until every owed result has arrived, so
  // the core is idle and registers may change.
  task automatic drain_results();
    chunk_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Offers one chunk at a falling edge, after random idle cycles, and holds it
  // until the rising edge at which the core takes it. Returns at a falling edge
  // with valid still high, so the next chunk can follow without a gap.
  task automatic offer_chunk(input logic [2*DATA_W-1:0] bytes16);
    while ($urandom_range(99) < sender_idle_pct) begin
      chunk_ch.valid <= 1'b0;
      @(negedge clk);
    end
    chunk_ch.valid     <= 1'b1;
    chunk_ch.data_low  <= bytes16[DATA_W-1:0];
    chunk_ch.data_high <= bytes16[2*DATA_W-1:DATA_W];
    do @(posedge clk); while (!chunk_ch.ready);
    chunks_sent++;
    @(negedge clk);
  endtask

  // Data extremes for the first chunks, random data after that.
  function automatic logic [2*DATA_W-1:0] directed_data(input int k);
    case (k)
      0:       return '0;
      1:       return '1;
      2:       return {{16{4'h5}}, {16{4'hA}}};
      3:       return {{16{4'hA}}, {16{4'h5}}};
      default: return {random_word(), random_word()};
    endcase
  endfunction

  initial begin
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = CFG_ROW_STRIDE;
    cfg_data           = '0;
    chunk_ch.valid     = 1'b0;
    chunk_ch.data_low  = '0;
    chunk_ch.data_high = '0;
    set_traffic(TRAFFIC_STEADY);
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The first two chunks run under the register reset values.
    for (int k = 0; k < 2; k++) offer_chunk(directed_data(k));
    drain_results();

    // A stride of zero falls back to one GOB, a zero height to one row, and a
    // block height above the maximum to the maximum. The rest of the first GOB
    // follows; the next GOB lies below the single row, so its chunk is skipped
    // and must come back with write enable low and a zero address.
    apply_setting(0, 0, 7);
    for (int k = 2; k < 33; k++) offer_chunk(directed_data(k));
    drain_results();

    // One GOB per block now, but the GOB row counter already sits past that
    // end. It must count as at its end, so the close of this GOB ends the image.
    apply_setting(64, 8, 0);
    for (int k = 0; k < 31; k++) offer_chunk(directed_data(k + 4));
    drain_results();

    // Stride and height above their maxima, then exactly at them.
    apply_setting(2**STRIDE_W - 1, 2**HEIGHT_W - 1, 6);
    for (int k = 0; k < 4; k++) offer_chunk(directed_data(k + 4));
    drain_results();
    apply_setting(65536, 16384, 5);
    for (int k = 0; k < 4; k++) offer_chunk(directed_data(k + 4));
    drain_results();

    // Random part. Most phases use small images so the counters carry through
    // every level and images end often; every third phase spans the full
    // register ranges. Settings change mid-image, which leaves counters past
    // their new ends. The traffic shape rotates through all four kinds.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph % 3 == 2)
        apply_setting($urandom_range(0, 2**STRIDE_W - 1), $urandom_range(0, 2**HEIGHT_W - 1),
                      $urandom_range(0, 7));
      else
        apply_setting($urandom_range(0, 320), $urandom_range(0, 48),
                      ($urandom_range(0, 9) > 7) ? $urandom_range(3, 7) : $urandom_range(0, 2));
      set_traffic(traffic_t'(ph % 4));
      for (int n = 0; n < PHASE_CHUNKS; n++) begin
        // In a steady phase the receiver holds off for a long stretch while
        // chunks keep coming, so the queue fills and the input stalls.
        if (ph == 4 && n == 16) hold_request = LONG_HOLD;
        // Elsewhere the sender pauses halfway until the core has emptied.
        if (ph == 6 && n == PHASE_CHUNKS / 2) drain_results();
        offer_chunk({random_word(), random_word()});
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d chunks under %0d register settings, with gaps, stalls and a hold-off.",
             chunks_sent, settings_used);
    $display("Checked %0d results: %0d skipped chunks, %0d image ends.",
             results_seen, skips_seen, image_ends);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
